// File: rtl/cbr_pkg.sv
package cbr_pkg;

  // Timer and register defaults.
  localparam int TIMER_WIDTH_DEF = 16;
  localparam int TIMEOUT_W       = 16;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd10;

  // Answer queue between the front and back ends.
  localparam int QUEUE_DEPTH = 2;

  // Input word kinds carried on tuser.
  localparam logic [1:0] KIND_BYTE  = 2'd0;
  localparam logic [1:0] KIND_ERROR = 2'd1;
  localparam logic [1:0] KIND_TICK  = 2'd2;

  // Command classes from the top two command bits.
  localparam logic [1:0] CMD_READ     = 2'd0;
  localparam logic [1:0] CMD_PING     = 2'd1;
  localparam logic [1:0] CMD_SET      = 2'd2;
  localparam logic [1:0] CMD_RESERVED = 2'd3;

  // Acknowledge codes.
  localparam logic [7:0] ACK_ERR  = 8'hFF;
  localparam logic [7:0] ACK_PING = 8'h40;
  localparam logic [7:0] ACK_SET  = 8'h80;
  localparam logic [7:0] ACK_READ = 8'h00;
  localparam logic [7:0] INV_MASK = 8'hFF;

  // Configuration register indexes.
  localparam logic CFG_IDX_TIMEOUT = 1'b0;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_WAIT = 2'b10
  } cbr_state_t;

  // One pending answer: the acknowledge byte and the actuator bits after it.
  typedef struct packed {
    logic [7:0] ack;
    logic [5:0] act;
  } cbr_entry_t;

endpackage

// File: rtl/cbr_front.sv
module cbr_front #(
  parameter int TIMER_WIDTH = cbr_pkg::TIMER_WIDTH_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  logic [1:0]                       kind,
  input  logic [7:0]                       rx_byte,
  input  logic [1:0]                       switches,
  input  logic [cbr_pkg::TIMEOUT_W-1:0]    timeout_ticks,
  output logic                             push,
  output cbr_pkg::cbr_entry_t              push_entry
);

  localparam int CMP_W = (TIMER_WIDTH > cbr_pkg::TIMEOUT_W) ? TIMER_WIDTH : cbr_pkg::TIMEOUT_W;

  cbr_pkg::cbr_state_t     state_r, state_nxt;
  logic [7:0]              cmd_r, cmd_nxt;
  logic [TIMER_WIDTH-1:0]  wait_r, wait_nxt, wait_inc;
  logic [5:0]              act_r, act_nxt;
  logic                    timed_out;

  assign wait_inc  = (wait_r == {TIMER_WIDTH{1'b1}}) ? wait_r : wait_r + 1'b1;
  assign timed_out = CMP_W'(wait_inc) >= CMP_W'(timeout_ticks);

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    wait_nxt   = wait_r;
    act_nxt    = act_r;
    push       = 1'b0;
    push_entry = '{ack: cbr_pkg::ACK_ERR, act: act_r};
    if (accept) begin
      priority if (kind == cbr_pkg::KIND_TICK) begin
        if (state_r == cbr_pkg::ST_WAIT) begin
          if (timed_out) begin
            state_nxt = cbr_pkg::ST_IDLE;
            wait_nxt  = '0;
            push      = 1'b1;
          end else begin
            wait_nxt = wait_inc;
          end
        end
      end else if (kind == cbr_pkg::KIND_BYTE) begin
        if (state_r == cbr_pkg::ST_IDLE) begin
          cmd_nxt   = rx_byte;
          state_nxt = cbr_pkg::ST_WAIT;
          wait_nxt  = '0;
        end else begin
          state_nxt = cbr_pkg::ST_IDLE;
          wait_nxt  = '0;
          if (rx_byte != (cmd_r ^ cbr_pkg::INV_MASK)) begin
            cmd_nxt = cbr_pkg::ACK_ERR;
            push    = 1'b1;
          end else begin
            unique case (cmd_r[7:6])
              cbr_pkg::CMD_READ: begin
                push           = 1'b1;
                push_entry.ack = cbr_pkg::ACK_READ | {6'd0, switches};
              end
              cbr_pkg::CMD_PING: begin
                push           = 1'b1;
                push_entry.ack = cbr_pkg::ACK_PING;
              end
              cbr_pkg::CMD_SET: begin
                act_nxt        = cmd_r[5:0];
                push           = 1'b1;
                push_entry.ack = cbr_pkg::ACK_SET | {2'd0, cmd_r[5:0]};
                push_entry.act = cmd_r[5:0];
              end
              cbr_pkg::CMD_RESERVED: begin
                push = 1'b0;
              end
            endcase
          end
        end
      end else begin
        // Error bytes and unused kinds are dropped.
        push = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cbr_pkg::ST_IDLE;
      wait_r  <= '0;
      act_r   <= '0;
      cmd_r   <= '0;
    end else begin
      state_r <= state_nxt;
      wait_r  <= wait_nxt;
      act_r   <= act_nxt;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

// File: rtl/cbr_fifo.sv
module cbr_fifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  cbr_pkg::cbr_entry_t push_entry,
  input  logic                pop,
  output logic                full,
  output logic                not_empty,
  output cbr_pkg::cbr_entry_t head
);

  localparam int DEPTH = cbr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cbr_pkg::cbr_entry_t entries_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic                do_push, do_pop;

  assign full      = (count_r == CNT_W'(DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = entries_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

// File: rtl/cbr_back.sv
module cbr_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_not_empty,
  input  cbr_pkg::cbr_entry_t q_head,
  output logic                q_pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_byte,
  output logic                out_last,
  output logic [5:0]          out_act
);

  logic       valid_r, valid_nxt;
  logic       last_r, last_nxt;
  logic [7:0] byte_r, byte_nxt;
  logic [5:0] act_r, act_nxt;
  logic       taken, slot_free;

  assign taken     = valid_r && out_ready;
  assign slot_free = !valid_r || (taken && last_r);
  assign q_pop     = slot_free && q_not_empty;

  always_comb begin
    valid_nxt = valid_r;
    last_nxt  = last_r;
    byte_nxt  = byte_r;
    act_nxt   = act_r;
    if (q_pop) begin
      // Load the acknowledge byte of the next answer.
      valid_nxt = 1'b1;
      last_nxt  = 1'b0;
      byte_nxt  = q_head.ack;
      act_nxt   = q_head.act;
    end else if (taken && !last_r) begin
      // Follow with the checksum byte.
      last_nxt = 1'b1;
      byte_nxt = byte_r ^ cbr_pkg::INV_MASK;
    end else if (taken) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      last_r  <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      last_r  <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
    act_r  <= act_nxt;
  end

  assign out_valid = valid_r;
  assign out_byte  = byte_r;
  assign out_last  = last_r;
  assign out_act   = act_r;

endmodule

// File: rtl/checked_command_byte_responder_core.sv
// Checked command responder. Each input word carries a kind on in_tuser (good byte, errored
// byte or time tick) and the received byte plus switch inputs on in_tdata. A good byte taken
// while idle is held as a command; the next good byte must be its inverse. A correct pair
// answers by command class (switch read, ping, actuator set; the reserved class answers
// nothing), while a bad checksum or a timeout answers 0xFF then 0x00. Every answer leaves as
// two output words, the acknowledge byte and then its inverse with tlast set, both carrying
// the actuator bits. The front end takes one input word per cycle whenever the two-entry
// answer queue has room; while that queue is full every input word waits, including words
// that would cause no answer. The back end serializer sends each answer as those two words and
// takes the next answer from the queue only while it is idle or its closing word is taken. The
// first answer byte passes through the answer queue and then the output register.
// The timeout register (byte address 0, reset value 10) counts ticks between command and
// checksum and must only be written while the block is idle.
module checked_command_byte_responder_core #(
  parameter int TIMER_WIDTH = cbr_pkg::TIMER_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Input words.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [7:0] rx_byte, [9:8] switches, [15:10] zero
  input  logic [1:0]  in_tuser,   // [1:0] kind
  // Answer words.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] tx_byte, [13:8] actuators, [15:14] zero
  output logic        out_tlast,
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic [cbr_pkg::TIMEOUT_W-1:0] timeout_r, timeout_nxt;
  logic                          cfg_wr;
  logic                          in_accept;
  logic                          push;
  cbr_pkg::cbr_entry_t           push_entry;
  cbr_pkg::cbr_entry_t           q_head;
  logic                          q_full, q_not_empty, q_pop;
  logic [7:0]                    out_byte;
  logic [5:0]                    out_act;

  // The register file is a single word at address bit 2 low; bit 2 high selects nothing.
  assign cfg_pready  = 1'b1;
  assign cfg_wr      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign timeout_nxt = (cfg_wr && cfg_paddr[2] == cbr_pkg::CFG_IDX_TIMEOUT)
                       ? cfg_pwdata[cbr_pkg::TIMEOUT_W-1:0] : timeout_r;
  assign cfg_prdata  = (cfg_paddr[2] == cbr_pkg::CFG_IDX_TIMEOUT)
                       ? {{(32 - cbr_pkg::TIMEOUT_W){1'b0}}, timeout_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= cbr_pkg::TIMEOUT_RESET;
    end else begin
      timeout_r <= timeout_nxt;
    end
  end

  // A word is taken only when the queue can hold any answer it might cause.
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  cbr_front #(
    .TIMER_WIDTH(TIMER_WIDTH)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (in_accept),
    .kind         (in_tuser),
    .rx_byte      (in_tdata[7:0]),
    .switches     (in_tdata[9:8]),
    .timeout_ticks(timeout_r),
    .push         (push),
    .push_entry   (push_entry)
  );

  cbr_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (q_head)
  );

  cbr_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_head     (q_head),
    .q_pop      (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_byte   (out_byte),
    .out_last   (out_tlast),
    .out_act    (out_act)
  );

  assign out_tdata = {2'b00, out_act, out_byte};

  // The front end never pushes an answer into a full queue.
  a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !q_full)
    else $error("answer pushed into full queue");

  // Errored bytes produce no answer.
  a_error_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && in_tuser == cbr_pkg::KIND_ERROR) |-> !push)
    else $error("errored byte produced an answer");

  // After an acknowledge byte is taken, its inverse follows as the closing word.
  a_pair_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tlast) |=>
      (out_tvalid && out_tlast && out_tdata[7:0] == ($past(out_tdata[7:0]) ^ 8'hFF)
       && out_tdata[13:8] == $past(out_tdata[13:8])))
    else $error("checksum byte did not follow acknowledge byte");

endmodule
